// File: hw/rtl/clcd_pkg.sv
// Types and constants for the 4-bit character LCD controller.
// Shared by the sequencer core, the top level and the testbench; no dependencies.
`timescale 1ns / 1ps

package clcd_pkg;

    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_CMD    = 3'd1;
    localparam logic [2:0] KIND_DATA   = 3'd2;
    localparam logic [2:0] KIND_CURSOR = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;
    localparam logic [2:0] KIND_INIT   = 3'd5;

    localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
    localparam logic [7:0] CMD_DISP_OFF   = 8'h08;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
    localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
    localparam logic [6:0] ROW1_BASE      = 7'h40;

    localparam logic [3:0] NIB_WAKE = 4'h3;
    localparam logic [3:0] NIB_FUNC = 4'h2;

    localparam logic [15:0] WAIT_STROBE     = 16'd1;
    localparam logic [15:0] WAIT_NIB_GAP    = 16'd50;
    localparam logic [15:0] WAIT_WAKE_FIRST = 16'd4550;
    localparam logic [15:0] WAIT_WAKE_NEXT  = 16'd200;
    localparam logic [15:0] WAIT_BYTE_END   = 16'd100;
    localparam logic [15:0] WAIT_INIT_END   = 16'd150;
    localparam logic [15:0] WAIT_CLEAR_END  = 16'd2100;

    typedef enum logic [4:0] {
        ST_IDLE      = 5'd0,
        ST_POWER     = 5'd1,
        ST_WAKE0_E   = 5'd2,
        ST_WAKE0_W   = 5'd3,
        ST_WAKE1_E   = 5'd4,
        ST_WAKE1_W   = 5'd5,
        ST_WAKE2_E   = 5'd6,
        ST_WAKE2_W   = 5'd7,
        ST_FUNC_E    = 5'd8,
        ST_FUNC_W    = 5'd9,
        ST_BYTE_HI_E = 5'd10,
        ST_BYTE_HI_W = 5'd11,
        ST_BYTE_LO_E = 5'd12,
        ST_BYTE_LO_W = 5'd13,
        ST_INIT_HI_E = 5'd14,
        ST_INIT_HI_W = 5'd15,
        ST_INIT_LO_E = 5'd16,
        ST_INIT_LO_W = 5'd17,
        ST_CLR_HI_E  = 5'd18,
        ST_CLR_HI_W  = 5'd19,
        ST_CLR_LO_E  = 5'd20,
        ST_CLR_LO_W  = 5'd21
    } step_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] byte_value;
        logic       row;
        logic [5:0] column;
    } item_t;

    typedef struct packed {
        logic [3:0] data_nibble;
        logic       reg_select;
        logic       enable;
        logic       busy_res;
        logic       accepted;
    } result_t;

endpackage

// File: hw/rtl/clcd_seq.sv
// Step sequencer core: prescaler, microsecond wait counter, step register and pin levels.
// Processes one transaction per strobe and presents its result combinationally; uses clcd_pkg.
`timescale 1ns / 1ps

module clcd_seq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_go,
    input  clcd_pkg::item_t    item,
    input  logic [7:0]         ticks_per_us,
    input  logic [15:0]        powerup_us,
    output clcd_pkg::result_t  res
);
    import clcd_pkg::*;

    step_t       step_reg, step_next, target;
    logic [15:0] wait_reg, wait_next, wait_enter;
    logic [7:0]  presc_reg, presc_next;
    logic [7:0]  pend_reg, pend_next;
    logic [3:0]  nib_reg, nib_next, nib_enter;
    logic        rs_reg, rs_next, rs_enter, rs_base;
    logic        e_reg, e_next, e_enter;
    logic        enter;
    logic        idle, tick_evt, req, us_done, expire;
    logic [7:0]  limit;
    logic [8:0]  presc_inc;
    logic [6:0]  cursor_addr;

    assign idle        = (step_reg == ST_IDLE);
    assign limit       = (ticks_per_us == 8'd0) ? 8'd1 : ticks_per_us;
    assign presc_inc   = {1'b0, presc_reg} + 9'd1;
    assign us_done     = (presc_inc >= {1'b0, limit});
    assign tick_evt    = item_go && (item.kind == KIND_TICK) && !idle;
    assign expire      = tick_evt && us_done && (wait_reg <= 16'd1);
    assign req         = item_go && idle && (item.kind >= KIND_CMD) && (item.kind <= KIND_INIT);
    assign cursor_addr = (item.row ? ROW1_BASE : 7'h00) + {1'b0, item.column};

    // next step selection
    always_comb begin
        target    = step_reg;
        enter     = 1'b0;
        pend_next = pend_reg;
        rs_base   = rs_reg;
        if (req) begin
            enter = 1'b1;
            case (item.kind) inside
                KIND_CMD, KIND_DATA: begin
                    pend_next = item.byte_value;
                    rs_base   = (item.kind == KIND_DATA);
                    target    = ST_BYTE_HI_E;
                end
                KIND_CURSOR: begin
                    pend_next = CMD_SET_DDRAM | {1'b0, cursor_addr};
                    rs_base   = 1'b0;
                    target    = ST_BYTE_HI_E;
                end
                KIND_CLEAR: begin
                    pend_next = CMD_CLEAR;
                    rs_base   = 1'b0;
                    target    = ST_CLR_HI_E;
                end
                default: begin
                    target = ST_POWER;
                end
            endcase
        end else if (expire) begin
            enter = 1'b1;
            unique case (step_reg) inside
                ST_POWER, ST_WAKE0_E, ST_WAKE0_W, ST_WAKE1_E, ST_WAKE1_W,
                ST_WAKE2_E, ST_WAKE2_W, ST_FUNC_E,
                ST_BYTE_HI_E, ST_BYTE_HI_W, ST_BYTE_LO_E,
                ST_INIT_HI_E, ST_INIT_HI_W, ST_INIT_LO_E,
                ST_CLR_HI_E, ST_CLR_HI_W, ST_CLR_LO_E: begin
                    target = step_t'(step_reg + 5'd1);
                end
                ST_FUNC_W: begin
                    pend_next = CMD_FUNC_SET;
                    target    = ST_INIT_HI_E;
                end
                ST_INIT_LO_W: begin
                    target = ST_INIT_HI_E;
                    case (pend_reg)
                        CMD_FUNC_SET:   pend_next = CMD_DISP_OFF;
                        CMD_DISP_OFF:   pend_next = CMD_CLEAR;
                        CMD_CLEAR:      pend_next = CMD_ENTRY_MODE;
                        CMD_ENTRY_MODE: pend_next = CMD_DISP_ON;
                        default:        target    = ST_IDLE;
                    endcase
                end
                default: begin
                    target = ST_IDLE;
                end
            endcase
        end
    end

    // pin levels and wait time on entering a step
    always_comb begin
        nib_enter  = nib_reg;
        rs_enter   = rs_base;
        e_enter    = 1'b0;
        wait_enter = 16'd0;
        unique case (target) inside
            ST_POWER: begin
                nib_enter  = 4'h0;
                rs_enter   = 1'b0;
                wait_enter = powerup_us;
            end
            ST_WAKE0_E, ST_WAKE1_E, ST_WAKE2_E: begin
                nib_enter  = NIB_WAKE;
                rs_enter   = 1'b0;
                e_enter    = 1'b1;
                wait_enter = WAIT_STROBE;
            end
            ST_FUNC_E: begin
                nib_enter  = NIB_FUNC;
                rs_enter   = 1'b0;
                e_enter    = 1'b1;
                wait_enter = WAIT_STROBE;
            end
            ST_WAKE0_W: begin
                rs_enter   = 1'b0;
                wait_enter = WAIT_WAKE_FIRST;
            end
            ST_WAKE1_W, ST_WAKE2_W, ST_FUNC_W: begin
                rs_enter   = 1'b0;
                wait_enter = WAIT_WAKE_NEXT;
            end
            ST_BYTE_HI_E, ST_INIT_HI_E, ST_CLR_HI_E: begin
                nib_enter  = pend_next[7:4];
                e_enter    = 1'b1;
                wait_enter = WAIT_STROBE;
            end
            ST_BYTE_LO_E, ST_INIT_LO_E, ST_CLR_LO_E: begin
                nib_enter  = pend_next[3:0];
                e_enter    = 1'b1;
                wait_enter = WAIT_STROBE;
            end
            ST_BYTE_HI_W, ST_INIT_HI_W, ST_CLR_HI_W: begin
                wait_enter = WAIT_NIB_GAP;
            end
            ST_BYTE_LO_W: begin
                wait_enter = WAIT_BYTE_END;
            end
            ST_INIT_LO_W: begin
                wait_enter = (pend_next == CMD_CLEAR) ? WAIT_CLEAR_END : WAIT_INIT_END;
            end
            ST_CLR_LO_W: begin
                wait_enter = WAIT_CLEAR_END;
            end
            default: begin
                e_enter = e_reg;
            end
        endcase
    end

    // state update
    always_comb begin
        step_next  = step_reg;
        wait_next  = wait_reg;
        presc_next = presc_reg;
        nib_next   = nib_reg;
        rs_next    = rs_reg;
        e_next     = e_reg;
        if (req) begin
            presc_next = 8'd0;
        end else if (tick_evt) begin
            if (!us_done) begin
                presc_next = presc_inc[7:0];
            end else begin
                presc_next = 8'd0;
                wait_next  = (wait_reg <= 16'd1) ? 16'd0 : wait_reg - 16'd1;
            end
        end
        if (enter) begin
            step_next = target;
            wait_next = wait_enter;
            nib_next  = nib_enter;
            rs_next   = rs_enter;
            e_next    = e_enter;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= ST_IDLE;
            wait_reg  <= 16'd0;
            presc_reg <= 8'd0;
            pend_reg  <= 8'd0;
            nib_reg   <= 4'h0;
            rs_reg    <= 1'b0;
            e_reg     <= 1'b0;
        end else if (item_go) begin
            step_reg  <= step_next;
            wait_reg  <= wait_next;
            presc_reg <= presc_next;
            pend_reg  <= pend_next;
            nib_reg   <= nib_next;
            rs_reg    <= rs_next;
            e_reg     <= e_next;
        end
    end

    assign res.data_nibble = nib_next;
    assign res.reg_select  = rs_next;
    assign res.enable      = e_next;
    assign res.busy_res    = (step_next != ST_IDLE);
    assign res.accepted    = req;

endmodule

// File: hw/rtl/char_lcd_4bit_interface.sv
// A transaction accepted on the s_ side is held in the input register, processed when it moves on
// to the output register, and its result is then valid on the m_ side.
// Throughput: one transaction per clock unless m_tready stalls; sequencer updates once per item.
// Reset (aresetn low, synchronous): both stages empty, sequencer idle, pins low,
// ticks_per_us back to 1.
// Top level of the 4-bit character LCD controller; uses clcd_pkg and clcd_seq.
`timescale 1ns / 1ps

module char_lcd_4bit_interface #(
    parameter int unsigned POWERUP_WAIT_US = 50000
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,   // ticks_per_us
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // byte_value[7:0], row[8], column[14:9], zero[15]
    input  logic [2:0]  s_tuser,     // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // data_nibble[3:0], enable[4], busy_res[5], accepted[6], zero[7]
    output logic        m_tuser      // reg_select[0]
);
    import clcd_pkg::*;

    logic [7:0]  tpu_reg;
    logic        in_valid_reg;
    item_t       in_item_reg;
    logic        out_valid_reg;
    result_t     out_res_reg;
    result_t     seq_res;
    logic        adv;

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpu_reg <= 8'd1;
        end else if (cfg_we) begin
            tpu_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.kind       <= s_tuser;
            in_item_reg.byte_value <= s_tdata[7:0];
            in_item_reg.row        <= s_tdata[8];
            in_item_reg.column     <= s_tdata[14:9];
        end
    end

    clcd_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_go      (adv),
        .item         (in_item_reg),
        .ticks_per_us (tpu_reg),
        .powerup_us   (16'(POWERUP_WAIT_US)),
        .res          (seq_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_res_reg <= seq_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg.accepted, out_res_reg.busy_res,
                       out_res_reg.enable, out_res_reg.data_nibble};
    assign m_tuser  = out_res_reg.reg_select;

endmodule

// File: hw/rtl/clcd_port_chk.sv
// Port checker for char_lcd_4bit_interface, attached by the bind at the end of this file.
// Sees only the top-level ports; depends on nothing else.
`timescale 1ns / 1ps

module clcd_port_chk (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transaction dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[6] |-> m_tdata[5])
        else $error("accepted request without busy");

    a_strobe_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tdata[5])
        else $error("enable strobe high while idle");

endmodule

bind char_lcd_4bit_interface clcd_port_chk u_clcd_port_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: bench/tb_char_lcd_4bit_interface.sv
// Testbench for the 4-bit character LCD controller: directed and random request traffic
// checked against a cycle-free predictor of the pin levels. Depends on clcd_pkg and
// char_lcd_4bit_interface.
`timescale 1ns / 1ps

module tb_char_lcd_4bit_interface;
    import clcd_pkg::*;

    localparam int unsigned POWERUP_US    = 50000;
    localparam logic [2:0]  KIND_SPARE6   = 3'd6;
    localparam logic [2:0]  KIND_SPARE7   = 3'd7;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned QUIET_LIMIT   = 5000;
    localparam int unsigned RANDOM_ITEMS  = 1850;
    localparam int unsigned RANDOM_SEQS   = 24;
    localparam int unsigned MAX_REPORTS   = 100;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'd0;
    logic [2:0]  s_tuser = KIND_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;

    // predicted controller state
    logic [7:0]  lcd_tpu;
    logic [7:0]  lcd_presc;
    logic [15:0] lcd_wait;
    step_t       lcd_step;
    logic [7:0]  lcd_byte;
    logic [3:0]  lcd_nib;
    logic        lcd_rs;
    logic        lcd_e;

    result_t     pin_queue[$];
    int unsigned errors = 0;
    int unsigned idle_pct = 0;
    logic        hold_trig = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned rx_stall = 0;
    int unsigned quiet_cycles = 0;

    char_lcd_4bit_interface #(
        .POWERUP_WAIT_US(POWERUP_US)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void lcd_enter(step_t s);
        lcd_step = s;
        case (s)
            ST_POWER: begin
                lcd_nib = 4'h0; lcd_rs = 1'b0; lcd_e = 1'b0; lcd_wait = 16'(POWERUP_US);
            end
            ST_WAKE0_E, ST_WAKE1_E, ST_WAKE2_E: begin
                lcd_nib = NIB_WAKE; lcd_rs = 1'b0; lcd_e = 1'b1; lcd_wait = 16'd1;
            end
            ST_FUNC_E: begin
                lcd_nib = NIB_FUNC; lcd_rs = 1'b0; lcd_e = 1'b1; lcd_wait = 16'd1;
            end
            ST_WAKE0_W: begin
                lcd_rs = 1'b0; lcd_e = 1'b0; lcd_wait = 16'd4550;
            end
            ST_WAKE1_W, ST_WAKE2_W, ST_FUNC_W: begin
                lcd_rs = 1'b0; lcd_e = 1'b0; lcd_wait = 16'd200;
            end
            ST_BYTE_HI_E, ST_INIT_HI_E, ST_CLR_HI_E: begin
                lcd_nib = lcd_byte[7:4]; lcd_e = 1'b1; lcd_wait = 16'd1;
            end
            ST_BYTE_HI_W, ST_INIT_HI_W, ST_CLR_HI_W: begin
                lcd_e = 1'b0; lcd_wait = 16'd50;
            end
            ST_BYTE_LO_E, ST_INIT_LO_E, ST_CLR_LO_E: begin
                lcd_nib = lcd_byte[3:0]; lcd_e = 1'b1; lcd_wait = 16'd1;
            end
            ST_BYTE_LO_W: begin
                lcd_e = 1'b0; lcd_wait = 16'd100;
            end
            ST_INIT_LO_W: begin
                lcd_e = 1'b0; lcd_wait = (lcd_byte == CMD_CLEAR) ? 16'd2100 : 16'd150;
            end
            ST_CLR_LO_W: begin
                lcd_e = 1'b0; lcd_wait = 16'd2100;
            end
            default: begin
                lcd_step = ST_IDLE; lcd_wait = 16'd0; lcd_presc = 8'd0;
            end
        endcase
    endfunction

    function automatic void lcd_advance();
        logic [7:0] nxt;
        nxt = 8'd0;
        case (lcd_step)
            ST_FUNC_W: begin
                lcd_byte = CMD_FUNC_SET;
                lcd_enter(ST_INIT_HI_E);
            end
            ST_INIT_LO_W: begin
                case (lcd_byte)
                    CMD_FUNC_SET:   nxt = CMD_DISP_OFF;
                    CMD_DISP_OFF:   nxt = CMD_CLEAR;
                    CMD_CLEAR:      nxt = CMD_ENTRY_MODE;
                    CMD_ENTRY_MODE: nxt = CMD_DISP_ON;
                    default:        nxt = 8'd0;
                endcase
                if (nxt != 8'd0) begin
                    lcd_byte = nxt;
                    lcd_enter(ST_INIT_HI_E);
                end else begin
                    lcd_enter(ST_IDLE);
                end
            end
            ST_IDLE, ST_BYTE_LO_W, ST_CLR_LO_W: lcd_enter(ST_IDLE);
            default: lcd_enter(step_t'(lcd_step + 5'd1));
        endcase
    endfunction

    function automatic void lcd_tick();
        logic [8:0] cnt;
        logic [8:0] lim;
        if (lcd_step != ST_IDLE) begin
            lim = (lcd_tpu == 8'd0) ? 9'd1 : {1'b0, lcd_tpu};
            cnt = {1'b0, lcd_presc} + 9'd1;
            if (cnt < lim) begin
                lcd_presc = cnt[7:0];
            end else begin
                lcd_presc = 8'd0;
                if (lcd_wait <= 16'd1) begin
                    lcd_wait = 16'd0;
                    lcd_advance();
                end else begin
                    lcd_wait = lcd_wait - 16'd1;
                end
            end
        end
    endfunction

    function automatic result_t lcd_predict(logic [2:0] kind, logic [7:0] bv, logic row,
                                            logic [5:0] col);
        result_t    r;
        logic       acc;
        logic [6:0] addr;
        acc = 1'b0;
        if (kind == KIND_TICK) begin
            lcd_tick();
        end else if (kind <= KIND_INIT && lcd_step == ST_IDLE) begin
            acc = 1'b1;
            lcd_presc = 8'd0;
            case (kind)
                KIND_CMD, KIND_DATA: begin
                    lcd_byte = bv; lcd_rs = (kind == KIND_DATA); lcd_e = 1'b0;
                    lcd_enter(ST_BYTE_HI_E);
                end
                KIND_CURSOR: begin
                    addr = (row ? ROW1_BASE : 7'd0) + {1'b0, col};
                    lcd_byte = CMD_SET_DDRAM | {1'b0, addr};
                    lcd_rs = 1'b0; lcd_e = 1'b0;
                    lcd_enter(ST_BYTE_HI_E);
                end
                KIND_CLEAR: begin
                    lcd_byte = CMD_CLEAR; lcd_rs = 1'b0; lcd_e = 1'b0;
                    lcd_enter(ST_CLR_HI_E);
                end
                default: lcd_enter(ST_POWER);
            endcase
        end
        r.data_nibble = lcd_nib;
        r.reg_select  = lcd_rs;
        r.enable      = lcd_e;
        r.busy_res    = (lcd_step != ST_IDLE);
        r.accepted    = acc;
        return r;
    endfunction

    task automatic send_item(input logic [2:0] kind, input logic [7:0] bv, input logic row,
                             input logic [5:0] col);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, col, row, bv};
        do @(posedge aclk); while (!s_tready);
        pin_queue.push_back(lcd_predict(kind, bv, row, col));
    endtask

    task automatic send_random(input logic [2:0] kind);
        logic [5:0] col;
        col = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(40, 63))
                                          : 6'($urandom_range(0, 39));
        send_item(kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), col);
    endtask

    task automatic run_to_idle(input int unsigned noise_pct);
        while (lcd_step != ST_IDLE) begin
            if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct)
                send_random(3'($urandom_range(1, 7)));
            else
                send_random(KIND_TICK);
        end
    endtask

    task automatic set_rate(input logic [7:0] v);
        s_tvalid <= 1'b0;
        while (pin_queue.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we  <= 1'b0;
        lcd_tpu = v;
    endtask

    task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    task automatic test_idle_behavior();
        idle_pct <= 20;
        send_item(KIND_TICK, 8'h00, 1'b0, 6'd0);
        send_item(KIND_TICK, 8'hFF, 1'b1, 6'd63);
        send_item(KIND_SPARE6, 8'hFF, 1'b1, 6'd63);
        send_item(KIND_SPARE7, 8'h00, 1'b0, 6'd0);
        send_random(KIND_TICK);
    endtask

    task automatic test_byte_writes();
        send_item(KIND_CMD, 8'h00, 1'b0, 6'd0);
        send_item(KIND_DATA, 8'h5A, 1'b1, 6'd63);
        run_to_idle(0);
        send_item(KIND_DATA, 8'hFF, 1'b0, 6'd0);
        run_to_idle(10);
        send_item(KIND_CMD, 8'hFF, 1'b1, 6'd0);
        run_to_idle(10);
        send_item(KIND_DATA, 8'h00, 1'b0, 6'd0);
        run_to_idle(0);
        // plain clear command is timed like any byte
        send_item(KIND_CMD, CMD_CLEAR, 1'b0, 6'd0);
        run_to_idle(5);
    endtask

    task automatic test_cursor();
        send_item(KIND_CURSOR, 8'h00, 1'b0, 6'd0);
        run_to_idle(5);
        send_item(KIND_CURSOR, 8'hFF, 1'b1, 6'd39);
        run_to_idle(5);
        send_item(KIND_CURSOR, 8'h00, 1'b1, 6'd63);
        run_to_idle(0);
        send_item(KIND_CURSOR, 8'h00, 1'b0, 6'd63);
        run_to_idle(5);
    endtask

    task automatic test_clear();
        send_item(KIND_CLEAR, 8'hA5, 1'b1, 6'd21);
        send_item(KIND_CLEAR, 8'h00, 1'b0, 6'd0);
        run_to_idle(2);
    endtask

    task automatic test_init_with_backpressure();
        idle_pct <= 10;
        send_item(KIND_INIT, 8'h00, 1'b0, 6'd0);
        repeat (100) send_random(KIND_TICK);
        // stall the result side long enough to back up the input
        hold_trig <= ~hold_trig;
        run_to_idle(1);
        send_item(KIND_DATA, 8'h41, 1'b0, 6'd0);
        run_to_idle(5);
    endtask

    task automatic test_rates();
        set_rate(8'd0);
        send_item(KIND_DATA, 8'hC3, 1'b0, 6'd0);
        run_to_idle(5);
        set_rate(8'd255);
        idle_pct <= 5;
        repeat (20) send_random(KIND_TICK);
        send_item(KIND_CMD, 8'h3C, 1'b0, 6'd0);
        repeat (300) send_random(KIND_TICK);
        // a lower rate ends the running microsecond on the next tick
        set_rate(8'd1);
        run_to_idle(1);
        set_rate(8'd2);
        send_item(KIND_DATA, 8'h96, 1'b0, 6'd0);
        run_to_idle(5);
    endtask

    task automatic test_random_traffic();
        int unsigned counted;
        int unsigned seqs;
        int unsigned pick;
        logic [2:0]  kind;
        counted = 0;
        seqs = 0;
        while (counted < RANDOM_ITEMS || seqs < RANDOM_SEQS) begin
            if (seqs % 6 == 0)
                set_rate(8'($urandom_range(0, 3)));
            idle_pct <= (seqs + 4 >= RANDOM_SEQS) ? 0 : $urandom_range(0, 2) * 15;
            if ($urandom_range(0, 3) == 0)
                send_random(($urandom_range(0, 1) == 0) ? KIND_TICK : KIND_SPARE7);
            pick = $urandom_range(0, 99);
            if (pick < 40)      kind = KIND_CMD;
            else if (pick < 80) kind = KIND_DATA;
            else if (pick < 95) kind = KIND_CURSOR;
            else                kind = KIND_CLEAR;
            send_random(kind);
            counted++;
            while (lcd_step != ST_IDLE) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_random(3'($urandom_range(1, 7)));
                end else begin
                    send_random(KIND_TICK);
                    counted++;
                end
            end
            seqs++;
        end
    endtask

    initial begin
        lcd_tpu   = 8'd1;
        lcd_presc = 8'd0;
        lcd_wait  = 16'd0;
        lcd_step  = ST_IDLE;
        lcd_byte  = 8'd0;
        lcd_nib   = 4'd0;
        lcd_rs    = 1'b0;
        lcd_e     = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_idle_behavior();
        test_byte_writes();
        test_cursor();
        test_clear();
        test_init_with_backpressure();
        test_rates();
        test_random_traffic();
        s_tvalid <= 1'b0;
        while (pin_queue.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    always @(posedge aclk) begin : drive_ready
        if (hold_trig != hold_seen) begin
            hold_seen = hold_trig;
            rx_stall  = HOLD_CYCLES;
        end else if (rx_stall == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rx_stall = $urandom_range(1, 8);
        end
        if (rx_stall != 0) begin
            rx_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.data_nibble = m_tdata[3:0];
            got.enable      = m_tdata[4];
            got.busy_res    = m_tdata[5];
            got.accepted    = m_tdata[6];
            got.reg_select  = m_tuser;
            if (pin_queue.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: transaction with nothing expected, actual %0h", $time, got);
            end else begin
                want = pin_queue.pop_front();
                check_field("data_nibble", want.data_nibble, got.data_nibble);
                check_field("reg_select", {3'b0, want.reg_select}, {3'b0, got.reg_select});
                check_field("enable", {3'b0, want.enable}, {3'b0, got.enable});
                check_field("busy_res", {3'b0, want.busy_res}, {3'b0, got.busy_res});
                check_field("accepted", {3'b0, want.accepted}, {3'b0, got.accepted});
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule
